>>> hw/rtl/i2c_adc_read_master_defines.svh
// Assertion macros shared by the I2C converter read master.
`ifndef I2C_ADC_READ_MASTER_DEFINES_SVH
`define I2C_ADC_READ_MASTER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define IAR_ASSERT_NOW(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define IAR_ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/iar_pkg.sv
// Types and constants shared by the I2C converter read master.
package iar_pkg;

  localparam int ADDR_W              = 7;
  localparam int PHASE_W             = 10;
  localparam int BYTE_W              = 8;
  localparam int BIT_CNT_W           = 3;
  localparam int TIMER_WIDTH_DEFAULT = 10;
  localparam int CFG_INDEX_W         = 1;
  localparam int CFG_DATA_W          = 10;

  localparam logic [ADDR_W-1:0]    DEVICE_ADDRESS_RESET = 7'h48;
  localparam logic [PHASE_W-1:0]   PHASE_TICKS_RESET    = 10'd5;
  localparam logic [BIT_CNT_W-1:0] BIT_LAST             = 3'd7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEVICE_ADDRESS = 1'b0,
    REG_PHASE_TICKS    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  device_address;
    logic [PHASE_W-1:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic              start_request;
    logic [BYTE_W-1:0] control_byte;
    logic              sda_in;
  } in_item_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_pull_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
  } out_item_t;

  typedef enum logic [19:0] {
    ST_IDLE     = 20'h00001,
    ST_S1_SETUP = 20'h00002,
    ST_S1_HOLD  = 20'h00004,
    ST_BIT_LOW  = 20'h00008,
    ST_BIT_HIGH = 20'h00010,
    ST_ACK_WAIT = 20'h00020,
    ST_ACK_CLK  = 20'h00040,
    ST_ACK_HOLD = 20'h00080,
    ST_P1_A     = 20'h00100,
    ST_P1_B     = 20'h00200,
    ST_P1_C     = 20'h00400,
    ST_S2_HOLD  = 20'h00800,
    ST_RD_HIGH  = 20'h01000,
    ST_RD_LOW   = 20'h02000,
    ST_NK_HIGH  = 20'h04000,
    ST_NK_LOW   = 20'h08000,
    ST_P2_A     = 20'h10000,
    ST_P2_B     = 20'h20000,
    ST_P2_C     = 20'h40000,
    ST_DONE     = 20'h80000
  } state_t;

  typedef enum logic [2:0] {
    BYTE_ADDR_WR = 3'b001,
    BYTE_CONTROL = 3'b010,
    BYTE_ADDR_RD = 3'b100
  } byte_sel_t;

endpackage

>>> hw/rtl/iar_cfg.sv
// Configuration register file: target address and bus phase length.
module iar_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [iar_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [iar_pkg::CFG_DATA_W-1:0]     cfg_data,
  output iar_pkg::cfg_t                      cfg
);

  logic [iar_pkg::ADDR_W-1:0]  device_address;
  logic [iar_pkg::PHASE_W-1:0] phase_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= iar_pkg::DEVICE_ADDRESS_RESET;
      phase_ticks    <= iar_pkg::PHASE_TICKS_RESET;
    end else if (cfg_valid) begin
      case (iar_pkg::cfg_reg_t'(cfg_index))
        iar_pkg::REG_DEVICE_ADDRESS: begin
          device_address <= cfg_data[iar_pkg::ADDR_W-1:0];
        end
        iar_pkg::REG_PHASE_TICKS: begin
          phase_ticks <= cfg_data[iar_pkg::PHASE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.device_address = device_address;
  assign cfg.phase_ticks    = phase_ticks;

endmodule

>>> hw/rtl/iar_seq.sv
// Bus sequencer: state registers and the per-tick next-state and output logic.
module iar_seq #(
  parameter int TIMER_WIDTH = iar_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  iar_pkg::in_item_t  in_item,
  input  iar_pkg::cfg_t      cfg,
  output iar_pkg::out_item_t result
);

  localparam int LIM_W = ((TIMER_WIDTH > iar_pkg::PHASE_W) ? TIMER_WIDTH : iar_pkg::PHASE_W) + 1;
  localparam logic [LIM_W-1:0] LIM_ONE = {{(LIM_W-1){1'b0}}, 1'b1};
  localparam logic [LIM_W-1:0] CAP     = LIM_ONE << TIMER_WIDTH;

  iar_pkg::state_t                   state, state_next;
  iar_pkg::byte_sel_t                byte_sel, byte_sel_next;
  logic [iar_pkg::BIT_CNT_W-1:0]     bit_count, bit_count_next;
  logic [iar_pkg::BYTE_W-1:0]        shift_reg, shift_reg_next;
  logic [iar_pkg::BYTE_W-1:0]        control_latch, control_latch_next;
  logic [iar_pkg::BYTE_W-1:0]        result_byte, result_byte_next;
  logic [TIMER_WIDTH-1:0]            timer, timer_next;

  logic [LIM_W-1:0]       lim_raw, lim, timer_inc;
  logic                   phase_last;
  logic [TIMER_WIDTH-1:0] timer_adv;
  logic                   bit_low;

  // Phase length: zero behaves as one, and it never exceeds the timer range.
  always_comb begin
    lim_raw = {{(LIM_W-iar_pkg::PHASE_W){1'b0}}, cfg.phase_ticks};
    if (lim_raw == '0) begin
      lim = LIM_ONE;
    end else if (lim_raw > CAP) begin
      lim = CAP;
    end else begin
      lim = lim_raw;
    end
    timer_inc  = {{(LIM_W-TIMER_WIDTH){1'b0}}, timer} + LIM_ONE;
    phase_last = (timer_inc >= lim);
    timer_adv  = phase_last ? '0 : timer_inc[TIMER_WIDTH-1:0];
    bit_low    = ~shift_reg[iar_pkg::BYTE_W-1];
  end

  always_comb begin
    state_next         = state;
    byte_sel_next      = byte_sel;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    control_latch_next = control_latch;
    result_byte_next   = result_byte;
    timer_next         = timer;
    result.scl_level    = 1'b1;
    result.sda_pull_low = 1'b0;
    result.busy_res     = 1'b1;
    result.done_res     = 1'b0;
    result.read_byte    = '0;

    case (state)
      iar_pkg::ST_S1_SETUP: begin
        timer_next = timer_adv;
        if (phase_last) begin
          state_next = iar_pkg::ST_S1_HOLD;
        end
      end
      iar_pkg::ST_S1_HOLD, iar_pkg::ST_S2_HOLD: begin
        result.sda_pull_low = 1'b1;
        timer_next = timer_adv;
        if (phase_last) begin
          bit_count_next = '0;
          state_next     = iar_pkg::ST_BIT_LOW;
          if (state == iar_pkg::ST_S2_HOLD) begin
            shift_reg_next = {cfg.device_address, 1'b1};
            byte_sel_next  = iar_pkg::BYTE_ADDR_RD;
          end else begin
            shift_reg_next = {cfg.device_address, 1'b0};
            byte_sel_next  = iar_pkg::BYTE_ADDR_WR;
          end
        end
      end
      iar_pkg::ST_BIT_LOW: begin
        result.scl_level    = 1'b0;
        result.sda_pull_low = bit_low;
        timer_next = timer_adv;
        if (phase_last) begin
          state_next = iar_pkg::ST_BIT_HIGH;
        end
      end
      iar_pkg::ST_BIT_HIGH: begin
        result.sda_pull_low = bit_low;
        timer_next = timer_adv;
        if (phase_last) begin
          if (bit_count == iar_pkg::BIT_LAST) begin
            bit_count_next = '0;
            state_next     = iar_pkg::ST_ACK_WAIT;
          end else begin
            bit_count_next = bit_count + 1'b1;
            shift_reg_next = {shift_reg[iar_pkg::BYTE_W-2:0], 1'b0};
            state_next     = iar_pkg::ST_BIT_LOW;
          end
        end
      end
      iar_pkg::ST_ACK_WAIT: begin
        result.scl_level = 1'b0;
        if (phase_last) begin
          if (!in_item.sda_in) begin
            timer_next = '0;
            state_next = iar_pkg::ST_ACK_CLK;
          end
        end else begin
          timer_next = timer_inc[TIMER_WIDTH-1:0];
        end
      end
      iar_pkg::ST_ACK_CLK: begin
        timer_next = timer_adv;
        if (phase_last) begin
          state_next = iar_pkg::ST_ACK_HOLD;
        end
      end
      iar_pkg::ST_ACK_HOLD: begin
        result.scl_level = 1'b0;
        // The phase only starts counting once the target has let SDA go.
        if (!(timer == '0 && !in_item.sda_in)) begin
          timer_next = timer_adv;
          if (phase_last) begin
            bit_count_next = '0;
            case (byte_sel)
              iar_pkg::BYTE_ADDR_WR: begin
                shift_reg_next = control_latch;
                byte_sel_next  = iar_pkg::BYTE_CONTROL;
                state_next     = iar_pkg::ST_BIT_LOW;
              end
              iar_pkg::BYTE_CONTROL: begin
                state_next = iar_pkg::ST_P1_A;
              end
              default: begin
                shift_reg_next = '0;
                state_next     = iar_pkg::ST_RD_HIGH;
              end
            endcase
          end
        end
      end
      iar_pkg::ST_P1_A, iar_pkg::ST_P2_A: begin
        result.scl_level    = 1'b0;
        result.sda_pull_low = 1'b1;
        timer_next = timer_adv;
        if (phase_last) begin
          state_next = (state == iar_pkg::ST_P1_A) ? iar_pkg::ST_P1_B : iar_pkg::ST_P2_B;
        end
      end
      iar_pkg::ST_P1_B, iar_pkg::ST_P2_B: begin
        result.sda_pull_low = 1'b1;
        timer_next = timer_adv;
        if (phase_last) begin
          state_next = (state == iar_pkg::ST_P1_B) ? iar_pkg::ST_P1_C : iar_pkg::ST_P2_C;
        end
      end
      iar_pkg::ST_P1_C: begin
        timer_next = timer_adv;
        if (phase_last) begin
          state_next = iar_pkg::ST_S2_HOLD;
        end
      end
      iar_pkg::ST_P2_C: begin
        timer_next = timer_adv;
        if (phase_last) begin
          state_next = iar_pkg::ST_DONE;
        end
      end
      iar_pkg::ST_RD_HIGH: begin
        timer_next = timer_adv;
        if (phase_last) begin
          shift_reg_next = {shift_reg[iar_pkg::BYTE_W-2:0], in_item.sda_in};
          state_next     = iar_pkg::ST_RD_LOW;
        end
      end
      iar_pkg::ST_RD_LOW: begin
        result.scl_level = 1'b0;
        timer_next = timer_adv;
        if (phase_last) begin
          if (bit_count == iar_pkg::BIT_LAST) begin
            bit_count_next   = '0;
            result_byte_next = shift_reg;
            state_next       = iar_pkg::ST_NK_HIGH;
          end else begin
            bit_count_next = bit_count + 1'b1;
            state_next     = iar_pkg::ST_RD_HIGH;
          end
        end
      end
      iar_pkg::ST_NK_HIGH: begin
        timer_next = timer_adv;
        if (phase_last) begin
          state_next = iar_pkg::ST_NK_LOW;
        end
      end
      iar_pkg::ST_NK_LOW: begin
        result.scl_level = 1'b0;
        timer_next = timer_adv;
        if (phase_last) begin
          state_next = iar_pkg::ST_P2_A;
        end
      end
      iar_pkg::ST_DONE: begin
        result.busy_res  = 1'b0;
        result.done_res  = 1'b1;
        result.read_byte = result_byte;
        timer_next = '0;
        state_next = iar_pkg::ST_IDLE;
      end
      default: begin
        result.busy_res = 1'b0;
        timer_next = '0;
        if (in_item.start_request) begin
          control_latch_next = in_item.control_byte;
          bit_count_next     = '0;
          state_next         = iar_pkg::ST_S1_SETUP;
        end else begin
          state_next = iar_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= iar_pkg::ST_IDLE;
      byte_sel      <= iar_pkg::BYTE_ADDR_WR;
      bit_count     <= '0;
      shift_reg     <= '0;
      control_latch <= '0;
      result_byte   <= '0;
      timer         <= '0;
    end else if (step) begin
      state         <= state_next;
      byte_sel      <= byte_sel_next;
      bit_count     <= bit_count_next;
      shift_reg     <= shift_reg_next;
      control_latch <= control_latch_next;
      result_byte   <= result_byte_next;
      timer         <= timer_next;
    end
  end

endmodule

>>> hw/rtl/i2c_adc_read_master.sv
// Top level of the I2C converter read master: input and result registers around the sequencer.
// Each tick transaction is registered in the input register, stepped through the sequencer
// and registered in the result register once that register has room.
// Throughput: one tick transaction per clock cycle while the result register is not stalled.
// Reset (rst, synchronous, active high) empties both registers, puts the sequencer in idle
// and loads device_address 0x48 and phase_ticks 5.
`include "i2c_adc_read_master_defines.svh"

module i2c_adc_read_master #(
  parameter int TIMER_WIDTH = iar_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  iar_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output iar_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [iar_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iar_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Input register: holds one tick transaction until the sequencer can take it.
  logic               in_full;
  iar_pkg::in_item_t  in_reg;
  // Result register: holds the sequencer's output until downstream takes it.
  iar_pkg::out_item_t out_reg;
  iar_pkg::out_item_t seq_result;
  iar_pkg::cfg_t      cfg;
  logic               advance;

  // The sequencer steps whenever a tick is waiting and the result register has room,
  // which includes the cycle in which the current result is being taken.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Configuration writes are always taken; the user must send them on an idle bus, unchecked.
  assign cfg_ready = 1'b1;

  iar_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  iar_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_item (in_reg),
    .cfg     (cfg),
    .result  (seq_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= seq_result;
    end
  end

  assign out_data = out_reg;

  // A sequencer step always leaves a result waiting in the output register.
  `IAR_ASSERT_NEXT(a_step_fills_result, clk, rst, advance, out_valid)
  // A full input register with a stalled result register must hold off new ticks.
  `IAR_ASSERT_NOW(a_stall_blocks_input, clk, rst, in_full && out_valid && !out_ready, !in_ready)
  // The done pulse is only ever reported with the busy flag clear.
  `IAR_ASSERT_NOW(a_done_not_busy, clk, rst, out_valid && out_data.done_res, !out_data.busy_res)
  // Outside the done tick the read byte field is zero.
  `IAR_ASSERT_NOW(a_byte_only_on_done, clk, rst, out_valid && !out_data.done_res,
                  out_data.read_byte == '0)

endmodule

>>> tb/i2c_adc_read_master_tb.sv
// Self-checking testbench for the I2C converter read master: tick stimulus, prediction, checks.
module i2c_adc_read_master_tb;
  import iar_pkg::*;

  // One row of the directed table. Where fixed_exp is set, want is the result typed in by hand;
  // otherwise the row is checked against the predicted bus tick.
  typedef struct packed {
    in_item_t  stim;
    logic      fixed_exp;
    out_item_t want;
  } directed_row_t;

  // Bus levels that can be read straight off the sequence: idle, and the first start setup.
  localparam out_item_t BUS_IDLE  = '{scl_level: 1'b1, sda_pull_low: 1'b0, busy_res: 1'b0,
                                      done_res: 1'b0, read_byte: 8'h00};
  localparam out_item_t BUS_SETUP = '{scl_level: 1'b1, sda_pull_low: 1'b0, busy_res: 1'b1,
                                      done_res: 1'b0, read_byte: 8'h00};
  localparam out_item_t NO_TYPED  = '0;

  localparam int DIRECTED_ROWS = 20;

  // Directed opening with the reset settings (address 0x48, five ticks per phase). The first
  // idle ticks carry the extremes of the control byte and of the data line. A request is then
  // taken, and a second request during the start setup must be ignored. The remaining rows run
  // into the start hold and the first address bit.
  localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{'{1'b0, 8'h00, 1'b0}, 1'b1, BUS_IDLE},
    '{'{1'b0, 8'hFF, 1'b1}, 1'b1, BUS_IDLE},
    '{'{1'b1, 8'hA5, 1'b0}, 1'b1, BUS_IDLE},
    '{'{1'b1, 8'h00, 1'b1}, 1'b1, BUS_SETUP},
    '{'{1'b0, 8'hFF, 1'b0}, 1'b0, NO_TYPED},
    '{'{1'b1, 8'h5A, 1'b1}, 1'b0, NO_TYPED},
    '{'{1'b0, 8'h00, 1'b0}, 1'b0, NO_TYPED},
    '{'{1'b1, 8'hFF, 1'b1}, 1'b0, NO_TYPED},
    '{'{1'b0, 8'h81, 1'b0}, 1'b0, NO_TYPED},
    '{'{1'b1, 8'h7E, 1'b1}, 1'b0, NO_TYPED},
    '{'{1'b0, 8'h3C, 1'b1}, 1'b0, NO_TYPED},
    '{'{1'b1, 8'hC3, 1'b0}, 1'b0, NO_TYPED},
    '{'{1'b0, 8'h01, 1'b1}, 1'b0, NO_TYPED},
    '{'{1'b0, 8'h80, 1'b0}, 1'b0, NO_TYPED},
    '{'{1'b1, 8'h55, 1'b1}, 1'b0, NO_TYPED},
    '{'{1'b0, 8'hAA, 1'b0}, 1'b0, NO_TYPED},
    '{'{1'b0, 8'h0F, 1'b1}, 1'b0, NO_TYPED},
    '{'{1'b1, 8'hF0, 1'b0}, 1'b0, NO_TYPED},
    '{'{1'b0, 8'h33, 1'b1}, 1'b0, NO_TYPED},
    '{'{1'b1, 8'hCC, 1'b0}, 1'b0, NO_TYPED}
  };

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Predicted state of the sequencer and its settings, advanced once per accepted tick.
  state_t               bus_state = ST_IDLE;
  byte_sel_t            byte_kind = BYTE_ADDR_WR;
  logic [BIT_CNT_W-1:0] bit_idx   = '0;
  logic [BYTE_W-1:0]    shift_q   = '0;
  logic [BYTE_W-1:0]    control_q = '0;
  logic [BYTE_W-1:0]    result_q  = '0;
  int unsigned          phase_cnt = 0;
  logic [ADDR_W-1:0]    dev_addr  = DEVICE_ADDRESS_RESET;
  logic [PHASE_W-1:0]   phase_len = PHASE_TICKS_RESET;

  // The byte that the simulated converter answers with in the read phase.
  logic [BYTE_W-1:0] slave_byte = 8'h00;

  out_item_t   expected_ticks [$];
  int unsigned mismatches = 0;
  int unsigned dones_seen = 0;
  // Set for the closing stretch of the run, where neither side idles.
  bit          calm       = 1'b0;

  always #10 clk = ~clk;

  i2c_adc_read_master i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // A phase length of zero behaves as one tick.
  function automatic int unsigned phase_limit();
    return (phase_len == '0) ? 1 : int'(phase_len);
  endfunction

  // Advances the phase counter and reports the last tick of the phase.
  function automatic bit phase_over();
    if (phase_cnt + 1 >= phase_limit()) begin
      phase_cnt = 0;
      return 1'b1;
    end
    phase_cnt++;
    return 1'b0;
  endfunction

  // Bus levels of one tick, taken from the state at the start of the tick, and the state
  // update that the tick causes.
  function automatic out_item_t predict_bus_tick(in_item_t tick);
    out_item_t lvl;
    logic      bit_low;
    lvl = '0;
    lvl.scl_level = 1'b1;
    lvl.busy_res = 1'b1;
    bit_low = ~shift_q[BYTE_W-1];
    case (bus_state)
      ST_S1_SETUP: if (phase_over()) bus_state = ST_S1_HOLD;
      ST_S1_HOLD, ST_S2_HOLD: begin
        lvl.sda_pull_low = 1'b1;
        if (phase_over()) begin
          bit_idx = '0;
          shift_q = {dev_addr, bus_state == ST_S2_HOLD};
          byte_kind = (bus_state == ST_S2_HOLD) ? BYTE_ADDR_RD : BYTE_ADDR_WR;
          bus_state = ST_BIT_LOW;
        end
      end
      ST_BIT_LOW: begin
        lvl.scl_level = 1'b0;
        lvl.sda_pull_low = bit_low;
        if (phase_over()) bus_state = ST_BIT_HIGH;
      end
      ST_BIT_HIGH: begin
        lvl.sda_pull_low = bit_low;
        if (phase_over()) begin
          if (bit_idx == BIT_LAST) begin
            bit_idx = '0;
            bus_state = ST_ACK_WAIT;
          end else begin
            bit_idx++;
            shift_q = shift_q << 1;
            bus_state = ST_BIT_LOW;
          end
        end
      end
      ST_ACK_WAIT: begin
        // The acknowledge wait has no timeout: it only ends once SDA is seen low.
        lvl.scl_level = 1'b0;
        if (phase_cnt + 1 >= phase_limit()) begin
          if (!tick.sda_in) begin
            phase_cnt = 0;
            bus_state = ST_ACK_CLK;
          end
        end else begin
          phase_cnt++;
        end
      end
      ST_ACK_CLK: if (phase_over()) bus_state = ST_ACK_HOLD;
      ST_ACK_HOLD: begin
        // At the start of this phase the target must have released SDA first.
        lvl.scl_level = 1'b0;
        if (phase_cnt != 0 || tick.sda_in) begin
          if (phase_over()) begin
            bit_idx = '0;
            case (byte_kind)
              BYTE_ADDR_WR: begin
                shift_q = control_q;
                byte_kind = BYTE_CONTROL;
                bus_state = ST_BIT_LOW;
              end
              BYTE_CONTROL: bus_state = ST_P1_A;
              default: begin
                shift_q = '0;
                bus_state = ST_RD_HIGH;
              end
            endcase
          end
        end
      end
      ST_P1_A, ST_P2_A: begin
        lvl.scl_level = 1'b0;
        lvl.sda_pull_low = 1'b1;
        if (phase_over()) bus_state = (bus_state == ST_P1_A) ? ST_P1_B : ST_P2_B;
      end
      ST_P1_B, ST_P2_B: begin
        lvl.sda_pull_low = 1'b1;
        if (phase_over()) bus_state = (bus_state == ST_P1_B) ? ST_P1_C : ST_P2_C;
      end
      ST_P1_C: if (phase_over()) bus_state = ST_S2_HOLD;
      ST_P2_C: if (phase_over()) bus_state = ST_DONE;
      ST_RD_HIGH: begin
        // Each data bit is taken on the last tick of its clock-high phase.
        if (phase_over()) begin
          shift_q = {shift_q[BYTE_W-2:0], tick.sda_in};
          bus_state = ST_RD_LOW;
        end
      end
      ST_RD_LOW: begin
        lvl.scl_level = 1'b0;
        if (phase_over()) begin
          if (bit_idx == BIT_LAST) begin
            bit_idx = '0;
            result_q = shift_q;
            bus_state = ST_NK_HIGH;
          end else begin
            bit_idx++;
            bus_state = ST_RD_HIGH;
          end
        end
      end
      ST_NK_HIGH: if (phase_over()) bus_state = ST_NK_LOW;
      ST_NK_LOW: begin
        lvl.scl_level = 1'b0;
        if (phase_over()) bus_state = ST_P2_A;
      end
      ST_DONE: begin
        // A request arriving in the done tick is dropped.
        lvl.busy_res = 1'b0;
        lvl.done_res = 1'b1;
        lvl.read_byte = result_q;
        phase_cnt = 0;
        bus_state = ST_IDLE;
      end
      default: begin
        lvl.busy_res = 1'b0;
        phase_cnt = 0;
        if (tick.start_request) begin
          control_q = tick.control_byte;
          bit_idx = '0;
          bus_state = ST_S1_SETUP;
        end else begin
          bus_state = ST_IDLE;
        end
      end
    endcase
    return lvl;
  endfunction

  // Builds the next tick from the predicted state. A well-behaved converter acknowledges,
  // releases SDA after the acknowledge and answers with slave_byte, with occasional late
  // acknowledges and slow releases. Outside a drain a sixteenth of the ticks carry a random
  // data line level, which breaks sequences at any point.
  function automatic in_item_t next_tick(bit draining);
    in_item_t tick;
    tick.control_byte = 8'($urandom_range(0, 255));
    if (bus_state == ST_IDLE) begin
      tick.start_request = !draining && $urandom_range(0, 3) != 0;
    end else begin
      tick.start_request = 1'($urandom_range(0, 1));
    end
    if (bus_state == ST_ACK_HOLD && byte_kind == BYTE_ADDR_RD) begin
      case ($urandom_range(0, 3))
        0:       slave_byte = 8'h00;
        1:       slave_byte = 8'hFF;
        default: slave_byte = 8'($urandom_range(0, 255));
      endcase
    end
    if (!draining && $urandom_range(0, 15) == 0) begin
      tick.sda_in = 1'($urandom_range(0, 1));
    end else begin
      case (bus_state)
        ST_ACK_WAIT: tick.sda_in = ($urandom_range(0, 3) == 0);
        ST_ACK_HOLD: tick.sda_in = ($urandom_range(0, 3) != 0);
        ST_RD_HIGH:  tick.sda_in = slave_byte[3'd7 - bit_idx];
        default:     tick.sda_in = 1'b1;
      endcase
    end
    return tick;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one tick transaction and holds it until it is taken. On acceptance the tick is
  // pushed through the predictor, and the result to expect is queued. Now and then the
  // sender pauses for a random burst afterwards.
  task automatic offer_tick(input in_item_t tick, input logic fixed_exp, input out_item_t want);
    out_item_t pred;
    in_data  <= tick;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_bus_tick(tick);
    expected_ticks.push_back(fixed_exp ? want : pred);
    if (pred.done_res) dones_seen++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Runs at least n_items random ticks and min_dones complete reads, then lets the current
  // read run to its end without new requests so that the sequencer is back in idle.
  task automatic run_phase(input int unsigned n_items, input int unsigned min_dones);
    int unsigned sent;
    int unsigned first_done;
    sent = 0;
    first_done = dones_seen;
    while (sent < n_items || dones_seen - first_done < min_dones) begin
      offer_tick(next_tick(1'b0), 1'b0, NO_TYPED);
      sent++;
    end
    while (bus_state != ST_IDLE) offer_tick(next_tick(1'b1), 1'b0, NO_TYPED);
  endtask

  // Stops offering ticks and waits until every expected result is out, plus a margin for the
  // input and result registers.
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] word);
    cfg_index <= idx;
    cfg_data  <= word;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_DEVICE_ADDRESS) dev_addr = word[ADDR_W-1:0];
    else phase_len = word[PHASE_W-1:0];
  endtask

  // Both registers are written back to back once the block has gone quiet. The address
  // word is ten bits wide on the port; its upper bits must be dropped.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] addr_word,
                              input logic [CFG_DATA_W-1:0] ticks_word);
    wait_until_quiet();
    write_reg(REG_DEVICE_ADDRESS, addr_word);
    write_reg(REG_PHASE_TICKS, ticks_word);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned drain_wait;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer_tick(DIRECTED[r].stim, DIRECTED[r].fixed_exp, DIRECTED[r].want);
    end
    run_phase(150, 1);

    // Smallest address with the shortest phase.
    program_regs(10'h000, 10'd1);
    run_phase(200, 2);
    // Largest address, and a phase length of zero, which must act as one tick.
    program_regs(10'h3FF, 10'd0);
    run_phase(200, 2);
    program_regs(10'($urandom_range(0, 1023)), 10'd2);
    run_phase(150, 1);
    program_regs(10'($urandom_range(0, 1023)), 10'($urandom_range(1, 3)));
    run_phase(150, 1);

    // Closing stretch at full rate on both sides.
    calm = 1'b1;
    program_regs(10'($urandom_range(0, 1023)), 10'd1);
    run_phase(150, 2);

    in_valid <= 1'b0;
    drain_wait = 0;
    while (expected_ticks.size() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (8) @(posedge clk);
    if (expected_ticks.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_ticks.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: checks every accepted result against the oldest expectation and stalls at
  // random outside the closing stretch. Once, after 150 results, it holds off so that the
  // block fills up and has to stop taking ticks.
  initial begin : result_side
    int unsigned stall_left;
    int unsigned results_seen;
    bit          long_hold_done;
    out_item_t   want;
    stall_left = 0;
    results_seen = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          mismatches++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("scl_level", want.scl_level, out_data.scl_level);
          check_field("sda_pull_low", want.sda_pull_low, out_data.sda_pull_low);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("read_byte", want.read_byte, out_data.read_byte);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        stall_left = 79;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends a run that hangs, well beyond the slowest correct run.
  initial begin : watchdog
    #400_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
